// File: src/keyframe_linear_interpolator_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define KFLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define KFLI_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: src/kfli_pkg.sv
`default_nettype none

package kfli_pkg;

  localparam int MAX_KEYS_DEF   = 16;
  localparam int TIME_BITS_DEF  = 24;

  localparam int KEY_INDEX_BITS = 4;
  localparam int VALUE_BITS     = 32;
  localparam int FRAME_BITS     = 16;
  localparam int KEY_COUNT_BITS = 5;
  localparam int KEY_COUNT_RST  = 2;
  localparam int KEY_COUNT_MIN  = 2;

  // Quotient bits resolved by the divider; anything larger saturates anyway.
  localparam int QUOT_BITS      = 33;
  localparam logic [QUOT_BITS:0] QUOT_CAP = (QUOT_BITS + 1)'(1) << QUOT_BITS;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    REG_KEY_COUNT = 1'b0,
    REG_LOOP_MODE = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAST,
    ST_WALK,
    ST_LLEN,
    ST_LWALK,
    ST_MOD,
    ST_FETCH0,
    ST_ARITH,
    ST_MUL,
    ST_DCHK,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: src/keyframe_linear_interpolator.sv
// Channel  Dir  Handshake             Contents
// s_axis   in   tvalid/tready         tuser: op; tdata: key_index, key_time, key_value, frame_time
// m_axis   out  tvalid/tready         tuser: finished; tdata: value (at most one beat per advance)
// apb      in   psel/penable/pready   key_count at 0x0, loop_mode at 0x4
//
// A keyframe write beat gives no result, nor does an advance in loop mode
// whose loop length (the last key time) is zero. An advance walks the keys
// with one memory read per cycle, then runs the interpolation divide if it
// needs one; a loop wrap adds a further divide. Both share the one restoring divider.
// Reset clears playback state and registers; the key memory is not cleared.
// One output register holds a result; a later result waits until it drains.
`default_nettype none
`include "keyframe_linear_interpolator_defines.svh"

module keyframe_linear_interpolator #(
  parameter int MAX_KEYS  = kfli_pkg::MAX_KEYS_DEF,
  parameter int TIME_BITS = kfli_pkg::TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // key_index, key_time, key_value, frame_time from bit 0 up, zero padded
  input  logic [((kfli_pkg::KEY_INDEX_BITS + TIME_BITS + kfli_pkg::VALUE_BITS
                  + kfli_pkg::FRAME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // op
  input  logic        s_axis_tuser_i,

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // value
  output logic [kfli_pkg::VALUE_BITS-1:0] m_axis_tdata_o,
  // finished
  output logic        m_axis_tuser_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import kfli_pkg::*;

  localparam int AW        = $clog2(MAX_KEYS);
  localparam int SW        = $clog2(MAX_KEYS + 1);
  localparam int EW        = TIME_BITS + 1;
  localparam int ESW       = ((EW > FRAME_BITS) ? EW : FRAME_BITS) + 1;
  localparam int DIFF_BITS = VALUE_BITS + 1;
  localparam int PW        = DIFF_BITS + EW;
  localparam int SUMW      = QUOT_BITS + 3;
  localparam int TIME_LSB  = KEY_INDEX_BITS;
  localparam int VAL_LSB   = TIME_LSB + TIME_BITS;
  localparam int FRAME_LSB = VAL_LSB + VALUE_BITS;

  // input beat
  logic                      in_acc;
  op_e                       in_op;
  logic [KEY_INDEX_BITS-1:0] in_idx;
  logic [TIME_BITS-1:0]      in_time;
  logic [VALUE_BITS-1:0]     in_value;
  logic [FRAME_BITS-1:0]     in_frame;
  logic                      idx_ok;

  // registers
  logic                      cfg_we;
  logic [KEY_COUNT_BITS-1:0] key_count_q;
  logic                      loop_q;
  logic [SW-1:0]             n_keys;
  logic [SW-1:0]             n_m1;
  logic [AW-1:0]             last_addr;

  // sequencer state
  state_e                    state_q, state_d;
  logic [SW-1:0]             seg_q, seg_d;
  logic [EW-1:0]             elapsed_q, elapsed_d;
  logic                      done_q, done_d;
  logic [FRAME_BITS-1:0]     frame_q, frame_d;
  logic                      zt_q, zt_d;
  logic [TIME_BITS-1:0]      t0_q, t0_d, t1_q, t1_d, loop_len_q, loop_len_d;
  logic [VALUE_BITS-1:0]     v0_q, v0_d, v1_q, v1_d;
  logic [DIFF_BITS-1:0]      a_q, a_d;
  logic [EW-1:0]             b_q, b_d;
  logic [TIME_BITS-1:0]      d_q, d_d;
  logic                      neg_q, neg_d;
  logic [PW-1:0]             p_q, p_d;
  logic [QUOT_BITS:0]        q_q, q_d;
  logic [VALUE_BITS-1:0]     res_q, res_d;
  logic                      res_fin_q, res_fin_d;

  logic [SW-1:0]             seg_p1, seg_p2, seg_m1, seg_lstart;

  // timer
  logic [FRAME_BITS-1:0]     frame_sel;
  logic [ESW-1:0]            el_sum;
  logic [EW-1:0]             el_sat;

  // interpolation datapath
  logic signed [TIME_BITS:0] den_s, den_neg;
  logic signed [DIFF_BITS-1:0] diff_s, diff_neg;
  logic signed [EW:0]        num_s, num_neg;
  logic [TIME_BITS-1:0]      den_abs;
  logic [DIFF_BITS-1:0]      diff_abs;
  logic [EW-1:0]             num_abs;
  logic                      p_over;
  logic signed [SUMW-1:0]    v0_ext, q_ext, sum_s;
  logic                      sum_ovf;
  logic [VALUE_BITS-1:0]     sum_sat;

  // key memory and divider
  logic                      mem_we;
  logic [AW-1:0]             raddr;
  logic [TIME_BITS-1:0]      rtime;
  logic [VALUE_BITS-1:0]     rvalue;
  logic                      div_start, div_busy, div_done;
  logic [TIME_BITS-1:0]      div_rem0, div_den, div_rem;
  logic [QUOT_BITS-1:0]      div_low, div_quot;

  // output register
  logic                      out_valid_q;
  logic [VALUE_BITS-1:0]     out_value_q;
  logic                      out_fin_q;
  logic                      out_free;
  logic                      out_load;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[TIME_LSB-1:0];
  assign in_time  = s_axis_tdata_i[VAL_LSB-1:TIME_LSB];
  assign in_value = s_axis_tdata_i[FRAME_LSB-1:VAL_LSB];
  assign in_frame = s_axis_tdata_i[FRAME_LSB+FRAME_BITS-1:FRAME_LSB];
  assign idx_ok   = (int'(in_idx) < MAX_KEYS);

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KEY_COUNT_BITS'(KEY_COUNT_RST);
      loop_q      <= 1'b0;
    end else if (cfg_we) begin
      case (reg_e'(paddr[2]))
        REG_KEY_COUNT: key_count_q <= pwdata[KEY_COUNT_BITS-1:0];
        REG_LOOP_MODE: loop_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata = (reg_e'(paddr[2]) == REG_LOOP_MODE) ? {31'b0, loop_q}
                                                      : {27'b0, key_count_q};

  always_comb begin
    if (int'(key_count_q) < KEY_COUNT_MIN) begin
      n_keys = SW'(KEY_COUNT_MIN);
    end else if (int'(key_count_q) > MAX_KEYS) begin
      n_keys = SW'(MAX_KEYS);
    end else begin
      n_keys = SW'(key_count_q);
    end
  end

  assign n_m1      = n_keys - SW'(1);
  assign last_addr = n_m1[AW-1:0];

  assign seg_p1     = seg_q + SW'(1);
  assign seg_p2     = seg_q + SW'(2);
  assign seg_m1     = seg_q - SW'(1);
  assign seg_lstart = (seg_q >= n_keys) ? '0 : seg_q;

  // saturating timer add; frame comes from the beat or, in loop mode, the latch
  assign frame_sel = (state_q == ST_LLEN) ? frame_q : in_frame;
  assign el_sum    = ESW'(elapsed_q) + ESW'(frame_sel);
  assign el_sat    = (el_sum[ESW-1:EW] != '0) ? '1 : el_sum[EW-1:0];

  // ---------------------------------------------------------- interpolation
  assign den_s    = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
  assign diff_s   = $signed({v1_q[VALUE_BITS-1], v1_q}) - $signed({v0_q[VALUE_BITS-1], v0_q});
  assign num_s    = $signed({1'b0, elapsed_q}) - $signed({2'b00, t0_q});
  assign den_neg  = -den_s;
  assign diff_neg = -diff_s;
  assign num_neg  = -num_s;
  assign den_abs  = den_s[TIME_BITS] ? den_neg[TIME_BITS-1:0] : den_s[TIME_BITS-1:0];
  assign diff_abs = diff_s[DIFF_BITS-1] ? diff_neg : diff_s;
  assign num_abs  = num_s[EW] ? num_neg[EW-1:0] : num_s[EW-1:0];

  // quotient would not fit the divider: it saturates the result anyway
  assign p_over = (p_q >= PW'({d_q, {QUOT_BITS{1'b0}}}));

  assign v0_ext  = {{(SUMW-VALUE_BITS){v0_q[VALUE_BITS-1]}}, v0_q};
  assign q_ext   = {{(SUMW-QUOT_BITS-1){1'b0}}, q_q};
  assign sum_s   = neg_q ? (v0_ext - q_ext) : (v0_ext + q_ext);
  assign sum_ovf = !((&sum_s[SUMW-1:VALUE_BITS-1]) || !(|sum_s[SUMW-1:VALUE_BITS-1]));
  assign sum_sat = sum_ovf ? (sum_s[SUMW-1] ? VAL_MIN : VAL_MAX) : sum_s[VALUE_BITS-1:0];

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seg_q     <= '0;
      elapsed_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      seg_q     <= seg_d;
      elapsed_q <= elapsed_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    zt_q       <= zt_d;
    t0_q       <= t0_d;
    t1_q       <= t1_d;
    loop_len_q <= loop_len_d;
    v0_q       <= v0_d;
    v1_q       <= v1_d;
    a_q        <= a_d;
    b_q        <= b_d;
    d_q        <= d_d;
    neg_q      <= neg_d;
    p_q        <= p_d;
    q_q        <= q_d;
    res_q      <= res_d;
    res_fin_q  <= res_fin_d;
  end

  always_comb begin
    state_d    = state_q;
    seg_d      = seg_q;
    elapsed_d  = elapsed_q;
    done_d     = done_q;
    frame_d    = frame_q;
    zt_d       = zt_q;
    t0_d       = t0_q;
    t1_d       = t1_q;
    loop_len_d = loop_len_q;
    v0_d       = v0_q;
    v1_d       = v1_q;
    a_d        = a_q;
    b_d        = b_q;
    d_d        = d_q;
    neg_d      = neg_q;
    p_d        = p_q;
    q_d        = q_q;
    res_d      = res_q;
    res_fin_d  = res_fin_q;
    mem_we     = 1'b0;
    raddr      = '0;
    div_start  = 1'b0;
    div_rem0   = '0;
    div_low    = '0;
    div_den    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_WRITE) begin
            if (idx_ok) begin
              mem_we    = 1'b1;
              elapsed_d = '0;
              seg_d     = '0;
              done_d    = 1'b0;
            end
          end else if (loop_q) begin
            frame_d = in_frame;
            raddr   = last_addr;
            state_d = ST_LLEN;
          end else if (done_q || (seg_q >= n_m1)) begin
            raddr   = last_addr;
            state_d = ST_LAST;
          end else begin
            elapsed_d = el_sat;
            raddr     = seg_p1[AW-1:0];
            state_d   = ST_WALK;
          end
        end
      end

      ST_LAST: begin
        done_d    = 1'b1;
        res_d     = rvalue;
        res_fin_d = 1'b1;
        state_d   = ST_EMIT;
      end

      // one-shot: rtime/rvalue hold key seg+1
      ST_WALK: begin
        if (elapsed_q > {1'b0, rtime}) begin
          seg_d = seg_p1;
          if (seg_p1 == n_m1) begin
            done_d    = 1'b1;
            res_d     = rvalue;
            res_fin_d = 1'b1;
            state_d   = ST_EMIT;
          end else begin
            raddr = seg_p2[AW-1:0];
          end
        end else begin
          t1_d    = rtime;
          v1_d    = rvalue;
          zt_d    = 1'b0;
          raddr   = seg_q[AW-1:0];
          state_d = ST_FETCH0;
        end
      end

      // loop: rtime holds the last key time, i.e. the loop length
      ST_LLEN: begin
        if (rtime == '0) begin
          state_d = ST_IDLE;
        end else begin
          loop_len_d = rtime;
          seg_d      = seg_lstart;
          elapsed_d  = el_sat;
          raddr      = seg_lstart[AW-1:0];
          state_d    = ST_LWALK;
        end
      end

      // loop: rtime/rvalue hold key seg
      ST_LWALK: begin
        if (elapsed_q > {1'b0, rtime}) begin
          if (seg_p1 == n_keys) begin
            seg_d     = '0;
            div_start = 1'b1;
            div_low   = QUOT_BITS'(elapsed_q - EW'(1));
            div_den   = loop_len_q;
            state_d   = ST_MOD;
          end else begin
            seg_d = seg_p1;
            raddr = seg_p1[AW-1:0];
          end
        end else begin
          t1_d = rtime;
          v1_d = rvalue;
          if (seg_q != '0) begin
            raddr = seg_m1[AW-1:0];
            zt_d  = 1'b0;
          end else begin
            // segment before key 0 starts at the last value, time zero
            raddr = last_addr;
            zt_d  = 1'b1;
          end
          state_d = ST_FETCH0;
        end
      end

      ST_MOD: begin
        if (div_done) begin
          elapsed_d = EW'(div_rem) + EW'(1);
          raddr     = '0;
          state_d   = ST_LWALK;
        end
      end

      ST_FETCH0: begin
        v0_d    = rvalue;
        t0_d    = zt_q ? '0 : rtime;
        state_d = ST_ARITH;
      end

      ST_ARITH: begin
        res_fin_d = 1'b0;
        if (den_s == '0) begin
          res_d   = v1_q;
          state_d = ST_EMIT;
        end else if ((diff_s == '0) || (num_s == '0)) begin
          res_d   = v0_q;
          state_d = ST_EMIT;
        end else begin
          a_d     = diff_abs;
          b_d     = num_abs;
          d_d     = den_abs;
          neg_d   = diff_s[DIFF_BITS-1] ^ num_s[EW] ^ den_s[TIME_BITS];
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        p_d     = a_q * b_q;
        state_d = ST_DCHK;
      end

      ST_DCHK: begin
        if (p_over) begin
          q_d     = QUOT_CAP;
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          div_rem0  = p_q[QUOT_BITS+TIME_BITS-1:QUOT_BITS];
          div_low   = p_q[QUOT_BITS-1:0];
          div_den   = d_q;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          q_d     = {1'b0, div_quot};
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        res_d     = sum_sat;
        res_fin_d = 1'b0;
        state_d   = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  kfli_keymem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW),
    .TW    (TIME_BITS),
    .VW    (VALUE_BITS)
  ) u_keymem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (AW'(in_idx)),
    .wtime_i  (in_time),
    .wvalue_i (in_value),
    .raddr_i  (raddr),
    .rtime_o  (rtime),
    .rvalue_o (rvalue)
  );

  kfli_div #(
    .DVW (TIME_BITS),
    .NB  (QUOT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem0_i  (div_rem0),
    .low_i   (div_low),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // ------------------------------------------------------------ output beat
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_q;
      out_fin_q   <= res_fin_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_fin_q;

  `KFLI_ASSERT_NEVER(a_div_restart, div_start && div_busy, "divider restarted while busy")
  `KFLI_ASSERT(a_ready_div_idle, s_axis_tready_o |-> !div_busy, "input ready during divide")
  `KFLI_ASSERT(a_out_from_emit, $rose(m_axis_tvalid_o) |-> $past(state_q == ST_EMIT), "beat without emit")
  `KFLI_ASSERT(a_done_oneshot, $rose(done_q) |-> !loop_q, "finished set in loop mode")

endmodule

`default_nettype wire

// File: src/kfli_keymem.sv
`default_nettype none

module kfli_keymem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int TW    = 24,
  parameter int VW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [TW-1:0] wtime_i,
  input  logic [VW-1:0] wvalue_i,
  input  logic [AW-1:0] raddr_i,
  output logic [TW-1:0] rtime_o,
  output logic [VW-1:0] rvalue_o
);

  logic [TW+VW-1:0] mem [DEPTH];
  logic [TW+VW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wtime_i, wvalue_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rtime_o  = rdata_q[TW+VW-1:VW];
  assign rvalue_o = rdata_q[VW-1:0];

endmodule

`default_nettype wire

// File: src/kfli_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is
// {rem0_i, low_i} with rem0_i below den_i, so NB steps give the full quotient.
module kfli_div #(
  parameter int DVW = 24,
  parameter int NB  = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] rem0_i,
  input  logic [NB-1:0]  low_i,
  input  logic [DVW-1:0] den_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [NB-1:0]  quot_o,
  output logic [DVW-1:0] rem_o
);

  localparam int CW = $clog2(NB + 1);

  logic           busy_q;
  logic           done_q;
  logic [CW-1:0]  cnt_q;
  logic [DVW-1:0] rem_q;
  logic [DVW-1:0] den_q;
  logic [NB-1:0]  low_q;

  logic [DVW:0]   trial;
  logic [DVW:0]   trial_sub;
  logic           ge;

  assign trial     = {rem_q, low_q[NB-1]};
  assign ge        = (trial >= {1'b0, den_q});
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift into the low end as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem0_i;
      low_q <= low_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[DVW-1:0] : trial[DVW-1:0];
      low_q <= {low_q[NB-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = low_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
